FILE: rtl/qrs_pkg.sv
package qrs_pkg;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        logic               has_real_roots;
        logic               lead_zero;
        logic               saturated;
    } qrs_out_t;

    localparam int unsigned QRS_FIELD_BITS = 16;

    // Quotients are produced with this many bits; a quotient that does not fit a signed 32-bit root saturates.
    localparam int unsigned QRS_Q_BITS = 34;

    // Per-item flags that ride along the pipeline next to the data.
    typedef struct packed {
        logic lead_zero;
        logic no_roots;
    } qrs_flags_t;

endpackage

FILE: rtl/qrs_disc.sv
// Discriminant front end: extends the coefficients, forms b*b/4 - a*c and
// takes its integer square root one result bit per pipeline stage.
module qrs_disc #(
    parameter int unsigned CB = 16,
    parameter int unsigned SW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  qrs_pkg::qrs_in_t        in_data,
    output logic                    out_valid,
    output qrs_pkg::qrs_flags_t     out_flags,
    output logic signed [CB-1:0]    out_a,
    output logic signed [CB:0]      out_b,
    output logic [SW:0]             out_s
);
    import qrs_pkg::*;

    localparam int unsigned DW = 2 * SW;

    // Stage 1: sign-extended coefficients and the two products.
    logic                 v1_reg;
    logic signed [CB-1:0] a1_reg;
    logic signed [CB-1:0] b1_reg;
    logic [2*CB-1:0]      bb1_reg;
    logic signed [2*CB:0] ac1_reg;

    logic signed [CB-1:0] a_ext;
    logic signed [CB-1:0] b_ext;
    logic signed [CB-1:0] c_ext;
    logic [CB-1:0]        ub;

    always_comb
    begin
        a_ext = CB'(signed'(in_data.coef_a));
        b_ext = CB'(signed'(in_data.coef_b));
        c_ext = CB'(signed'(in_data.coef_c));
        ub    = b_ext[CB-1] ? CB'(-b_ext) : CB'(b_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg  <= a_ext;
        b1_reg  <= b_ext;
        bb1_reg <= ub * ub;
        ac1_reg <= (2*CB+1)'(a_ext * c_ext);
    end

    // Stage 2: d4 = floor(b*b/4) - a*c and the special cases.
    logic                 v2_reg;
    logic signed [CB-1:0] a2_reg;
    logic signed [CB:0]   b2_reg;
    logic [DW-1:0]        d2_reg;
    logic                 r2_reg;
    qrs_flags_t           f2_reg;

    logic signed [2*CB+1:0] d4;

    assign d4 = (2*CB+2)'($signed({2'b00, bb1_reg[2*CB-1:2]})) - (2*CB+2)'(ac1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a2_reg           <= a1_reg;
        b2_reg           <= (CB+1)'(b1_reg);
        d2_reg           <= d4[2*CB+1] ? '0 : DW'(d4);
        r2_reg           <= (|bb1_reg[1:0]) && !d4[2*CB+1];
        f2_reg.lead_zero <= (a1_reg == '0);
        f2_reg.no_roots  <= d4[2*CB+1];
    end

    // Square-root stages, most significant result bit first. Each stage holds
    // the partial root and remainder of the restoring method.
    logic                 vs_reg [SW+1];
    logic signed [CB-1:0] as_reg [SW+1];
    logic signed [CB:0]   bs_reg [SW+1];
    logic [DW-1:0]        rem_reg [SW+1];
    logic [SW-1:0]        root_reg [SW+1];
    logic                 rs_reg [SW+1];
    qrs_flags_t           fs_reg [SW+1];

    always_comb
    begin
        vs_reg[0]   = v2_reg;
        as_reg[0]   = a2_reg;
        bs_reg[0]   = b2_reg;
        rem_reg[0]  = d2_reg;
        root_reg[0] = '0;
        rs_reg[0]   = r2_reg;
        fs_reg[0]   = f2_reg;
    end

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        localparam int unsigned BIT = SW - 1 - k;
        logic [DW+1:0] trial;
        logic [DW+1:0] rem_wide;

        always_comb
        begin
            trial    = ((DW+2)'(root_reg[k]) << (BIT + 1)) + ((DW+2)'(1) << (2 * BIT));
            rem_wide = (DW+2)'(rem_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[k+1] <= 1'b0;
            end
            else
            begin
                vs_reg[k+1] <= vs_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            as_reg[k+1] <= as_reg[k];
            bs_reg[k+1] <= bs_reg[k];
            rs_reg[k+1] <= rs_reg[k];
            fs_reg[k+1] <= fs_reg[k];
            if (rem_wide >= trial)
            begin
                rem_reg[k+1]  <= DW'(rem_wide - trial);
                root_reg[k+1] <= root_reg[k] | (SW'(1) << BIT);
            end
            else
            begin
                rem_reg[k+1]  <= rem_reg[k];
                root_reg[k+1] <= root_reg[k];
            end
        end
    end

    // Final stage: s = 2t or 2t+1 from the leftover d4 - t*t compared with t.
    logic                 vf_reg;
    logic signed [CB-1:0] af_reg;
    logic signed [CB:0]   bf_reg;
    logic [SW:0]          sf_reg;
    qrs_flags_t           ff_reg;

    logic [DW:0] e_rem;
    logic [DW:0] e_t;
    logic        add_one;

    always_comb
    begin
        e_rem   = (DW+1)'(rem_reg[SW]);
        e_t     = (DW+1)'(root_reg[SW]);
        add_one = (e_rem > e_t) || ((e_rem == e_t) && rs_reg[SW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= vs_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        af_reg <= as_reg[SW];
        bf_reg <= bs_reg[SW];
        sf_reg <= {root_reg[SW], add_one};
        ff_reg <= fs_reg[SW];
    end

    assign out_valid = vf_reg;
    assign out_flags = ff_reg;
    assign out_a     = af_reg;
    assign out_b     = bf_reg;
    assign out_s     = sf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        vf_reg |-> !(ff_reg.lead_zero && ff_reg.no_roots && (sf_reg != '0)))
        else $error("negative discriminant produced a nonzero root");
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg)
        else $error("item lost between product and discriminant stages");
    assert property (@(posedge clk) disable iff (!rst_n)
        (vf_reg && ff_reg.no_roots) |-> (sf_reg == '0))
        else $error("root nonzero for a negative discriminant");

endmodule

FILE: rtl/qrs_div.sv
// Pipelined restoring divider: (|num| << 16 + |a|) / (2|a|), one quotient bit
// per stage, followed by sign, saturation and output packing.
module qrs_div #(
    parameter int unsigned CB = 16,
    parameter int unsigned SW = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  qrs_pkg::qrs_flags_t     in_flags,
    input  logic signed [CB-1:0]    in_a,
    input  logic signed [CB:0]      in_b,
    input  logic [SW:0]             in_s,
    output logic                    out_valid,
    output qrs_pkg::qrs_out_t       out_data
);
    import qrs_pkg::*;

    localparam int unsigned NW = CB + 2;              // |-b +- s| width
    localparam int unsigned DN = NW + 16 + 1;         // dividend width
    localparam int unsigned QB = QRS_Q_BITS;
    localparam int unsigned RW = CB + 2;              // remainder width

    // Stage 0: numerators, magnitudes and signs.
    logic             v0_reg;
    logic [DN-1:0]    np0_reg;
    logic [DN-1:0]    nm0_reg;
    logic [CB:0]      den0_reg;
    logic             sp0_reg;
    logic             sm0_reg;
    qrs_flags_t       f0_reg;

    logic signed [NW:0] nplus;
    logic signed [NW:0] nminus;
    logic [CB-1:0]      ua;
    logic [NW-1:0]      unp;
    logic [NW-1:0]      unm;

    always_comb
    begin
        nplus  = -(NW+1)'(in_b) + (NW+1)'($signed({1'b0, in_s}));
        nminus = -(NW+1)'(in_b) - (NW+1)'($signed({1'b0, in_s}));
        ua     = in_a[CB-1] ? CB'(-in_a) : CB'(in_a);
        unp    = nplus[NW] ? NW'(-nplus) : NW'(nplus);
        unm    = nminus[NW] ? NW'(-nminus) : NW'(nminus);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        np0_reg  <= (DN'(unp) << 16) + DN'(ua);
        nm0_reg  <= (DN'(unm) << 16) + DN'(ua);
        den0_reg <= {ua, 1'b0};
        sp0_reg  <= nplus[NW] ^ in_a[CB-1];
        sm0_reg  <= nminus[NW] ^ in_a[CB-1];
        f0_reg   <= in_flags;
    end

    // Quotient bits above QB-1 only decide saturation; they are folded into a
    // sticky overflow bit computed in stage 0 of the chain.
    logic             vq_reg [QB+1];
    logic [DN-1:0]    np_reg [QB+1];
    logic [DN-1:0]    nm_reg [QB+1];
    logic [RW-1:0]    rp_reg [QB+1];
    logic [RW-1:0]    rm_reg [QB+1];
    logic [QB-1:0]    qp_reg [QB+1];
    logic [QB-1:0]    qm_reg [QB+1];
    logic [CB:0]      dq_reg [QB+1];
    logic             sp_reg [QB+1];
    logic             sm_reg [QB+1];
    logic             op_reg [QB+1];
    logic             om_reg [QB+1];
    qrs_flags_t       fq_reg [QB+1];

    logic          ovp;
    logic          ovm;

    always_comb
    begin
        // Quotient reaches 2^QB exactly when the dividend >= den << QB.
        ovp = (DN+QB)'(np0_reg) >= ((DN+QB)'(den0_reg) << QB);
        ovm = (DN+QB)'(nm0_reg) >= ((DN+QB)'(den0_reg) << QB);
        vq_reg[0] = v0_reg;
        np_reg[0] = np0_reg;
        nm_reg[0] = nm0_reg;
        rp_reg[0] = '0;
        rm_reg[0] = '0;
        qp_reg[0] = '0;
        qm_reg[0] = '0;
        dq_reg[0] = den0_reg;
        sp_reg[0] = sp0_reg;
        sm_reg[0] = sm0_reg;
        op_reg[0] = ovp;
        om_reg[0] = ovm;
        fq_reg[0] = f0_reg;
    end

    // Partial remainders start from the dividend bits above QB.
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int unsigned BIT = QB - 1 - k;
        logic [RW:0]   tp;
        logic [RW:0]   tm;
        logic [RW:0]   dw;

        always_comb
        begin
            if (k == 0)
            begin
                tp = (RW+1)'(np_reg[k] >> QB);
                tm = (RW+1)'(nm_reg[k] >> QB);
            end
            else
            begin
                tp = (RW+1)'(rp_reg[k]);
                tm = (RW+1)'(rm_reg[k]);
            end
            tp = (tp << 1) | (RW+1)'(np_reg[k][BIT]);
            tm = (tm << 1) | (RW+1)'(nm_reg[k][BIT]);
            dw = (RW+1)'(dq_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vq_reg[k+1] <= 1'b0;
            end
            else
            begin
                vq_reg[k+1] <= vq_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            np_reg[k+1] <= np_reg[k];
            nm_reg[k+1] <= nm_reg[k];
            dq_reg[k+1] <= dq_reg[k];
            sp_reg[k+1] <= sp_reg[k];
            sm_reg[k+1] <= sm_reg[k];
            op_reg[k+1] <= op_reg[k];
            om_reg[k+1] <= om_reg[k];
            fq_reg[k+1] <= fq_reg[k];
            if (tp >= dw)
            begin
                rp_reg[k+1] <= RW'(tp - dw);
                qp_reg[k+1] <= qp_reg[k] | (QB'(1) << BIT);
            end
            else
            begin
                rp_reg[k+1] <= RW'(tp);
                qp_reg[k+1] <= qp_reg[k];
            end
            if (tm >= dw)
            begin
                rm_reg[k+1] <= RW'(tm - dw);
                qm_reg[k+1] <= qm_reg[k] | (QB'(1) << BIT);
            end
            else
            begin
                rm_reg[k+1] <= RW'(tm);
                qm_reg[k+1] <= qm_reg[k];
            end
        end
    end

    // Output stage: saturation, sign and the invalid cases.
    logic     vo_reg;
    qrs_out_t do_reg;

    logic [31:0] rplus;
    logic [31:0] rminus;
    logic        satp;
    logic        satm;
    logic        valid_roots;

    always_comb
    begin
        valid_roots = !fq_reg[QB].lead_zero && !fq_reg[QB].no_roots;
        if (!sp_reg[QB])
        begin
            satp  = op_reg[QB] || (qp_reg[QB] > QB'(32'h7FFF_FFFF));
            rplus = satp ? 32'h7FFF_FFFF : qp_reg[QB][31:0];
        end
        else
        begin
            satp  = op_reg[QB] || (qp_reg[QB] > QB'(33'h1_0000_0000 >> 1));
            rplus = satp ? 32'h8000_0000 : 32'(-qp_reg[QB]);
        end
        if (!sm_reg[QB])
        begin
            satm   = om_reg[QB] || (qm_reg[QB] > QB'(32'h7FFF_FFFF));
            rminus = satm ? 32'h7FFF_FFFF : qm_reg[QB][31:0];
        end
        else
        begin
            satm   = om_reg[QB] || (qm_reg[QB] > QB'(33'h1_0000_0000 >> 1));
            rminus = satm ? 32'h8000_0000 : 32'(-qm_reg[QB]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= vq_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        do_reg.root_plus      <= valid_roots ? rplus : '0;
        do_reg.root_minus     <= valid_roots ? rminus : '0;
        do_reg.has_real_roots <= valid_roots;
        do_reg.lead_zero      <= fq_reg[QB].lead_zero;
        do_reg.saturated      <= valid_roots && (satp || satm);
    end

    assign out_valid = vo_reg;
    assign out_data  = do_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> !(do_reg.has_real_roots && do_reg.lead_zero))
        else $error("roots reported with a zero leading coefficient");
    assert property (@(posedge clk) disable iff (!rst_n)
        (vo_reg && !do_reg.has_real_roots) |-> (do_reg.root_plus == '0 && !do_reg.saturated))
        else $error("invalid result carries root data");
    assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |=> vq_reg[1])
        else $error("item lost entering the divider chain");

endmodule

FILE: rtl/quadratic_root_solver.sv
// Quadratic real-root solver, fully pipelined.
// Input: coef_a, coef_b, coef_c in the packed struct "coef", transferred at a
// rising edge with start high and busy low. busy is low while FRAC_BITS is at
// most 64, so a new coefficient set may be transferred every cycle.
// Output: one result per input, shown in "result" for exactly one cycle with
// done high. The receiver cannot stall; every result is a completed transfer.
// The pipeline is made of two product and discriminant stages, one square-root
// stage per root bit (coefficient bits capped at 16) plus a correction stage, a
// numerator stage, one divider stage per quotient bit (34) and an output
// stage. Throughput is one item per cycle while busy is low; the depth is set
// by the bit-per-stage square-root and divider chains.
// Reset clears every valid bit, so no result appears until items are fed.
// FRAC_BITS does not change the datapath (the scale cancels in each quotient); above 64 it holds busy high.
module quadratic_root_solver #(
    parameter int unsigned COEF_BITS = 16,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  qrs_pkg::qrs_in_t   coef,
    output logic               done,
    output qrs_pkg::qrs_out_t  result
);
    import qrs_pkg::*;

    localparam int unsigned CB = (COEF_BITS > QRS_FIELD_BITS) ? QRS_FIELD_BITS : COEF_BITS;
    localparam int unsigned SW = CB;
    localparam int unsigned FB = FRAC_BITS;

    logic                 d_valid;
    qrs_flags_t           d_flags;
    logic signed [CB-1:0] d_a;
    logic signed [CB:0]   d_b;
    logic [SW:0]          d_s;
    logic                 accept;

    assign busy   = (FB > 64);
    assign accept = start && !busy;

    qrs_disc #(.CB(CB), .SW(SW)) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (coef),
        .out_valid (d_valid),
        .out_flags (d_flags),
        .out_a     (d_a),
        .out_b     (d_b),
        .out_s     (d_s)
    );

    qrs_div #(.CB(CB), .SW(SW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_flags  (d_flags),
        .in_a      (d_a),
        .in_b      (d_b),
        .in_s      (d_s),
        .out_valid (done),
        .out_data  (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("solver reported busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.lead_zero && result.saturated))
        else $error("saturation flagged with zero leading coefficient");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.has_real_roots && result.lead_zero))
        else $error("conflicting result flags");

endmodule
